// ===== src/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and codes of the source text tokenizer: transfer payloads,
// token kinds, error codes, operator codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_byte;
        logic       end_of_source;
    } t_byte_in;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [4:0]  punct_code;
        logic [31:0] line_number;
        logic [31:0] text_start;
        logic [31:0] text_length;
        logic [62:0] int_value;
        logic [1:0]  error_code;
        logic        last_of_run;
    } t_tok;

    localparam logic [2:0] K_NL    = 3'd0;
    localparam logic [2:0] K_STR   = 3'd1;
    localparam logic [2:0] K_INT   = 3'd2;
    localparam logic [2:0] K_FLT   = 3'd3;
    localparam logic [2:0] K_ID    = 3'd4;
    localparam logic [2:0] K_PUNCT = 3'd5;
    localparam logic [2:0] K_EOF   = 3'd6;
    localparam logic [2:0] K_ERR   = 3'd7;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_UNTERM   = 2'd1;
    localparam logic [1:0] E_INVALID  = 2'd2;
    localparam logic [1:0] E_OVERFLOW = 2'd3;

    localparam logic [4:0] P_NONE    = 5'd0;
    localparam logic [4:0] P_EQEQ    = 5'd0;
    localparam logic [4:0] P_NE      = 5'd1;
    localparam logic [4:0] P_LE      = 5'd2;
    localparam logic [4:0] P_GE      = 5'd3;
    localparam logic [4:0] P_ANDAND  = 5'd4;
    localparam logic [4:0] P_OROR    = 5'd5;
    localparam logic [4:0] P_ASSIGN  = 5'd6;
    localparam logic [4:0] P_LT      = 5'd7;
    localparam logic [4:0] P_GT      = 5'd8;
    localparam logic [4:0] P_PLUS    = 5'd9;
    localparam logic [4:0] P_MINUS   = 5'd10;
    localparam logic [4:0] P_STAR    = 5'd11;
    localparam logic [4:0] P_SLASH   = 5'd12;
    localparam logic [4:0] P_PERCENT = 5'd13;
    localparam logic [4:0] P_LPAREN  = 5'd14;
    localparam logic [4:0] P_RPAREN  = 5'd15;
    localparam logic [4:0] P_LBRACK  = 5'd16;
    localparam logic [4:0] P_RBRACK  = 5'd17;
    localparam logic [4:0] P_COMMA   = 5'd18;
    localparam logic [4:0] P_COLON   = 5'd19;
    localparam logic [4:0] P_BANG    = 5'd20;
    localparam logic [4:0] P_DOT     = 5'd21;

    localparam logic [7:0] CH_BOM0   = 8'hEF;
    localparam logic [7:0] CH_BOM1   = 8'hBB;
    localparam logic [7:0] CH_BOM2   = 8'hBF;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    localparam logic [62:0] INT_MAX = {63{1'b1}};

endpackage

`default_nettype wire

// ===== src/source_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming lexer: one source byte per transfer in, token descriptors out.
// Results of an item are registered and appear in the cycle after its transfer.
// Throughput: one item per cycle while each item gives at most one result and
// the output is not stalled; an item with more results stalls the input while
// the four-entry result buffer drains.
// Reset: synchronous, active low; lexer back to the byte order mark check,
// result buffer empty.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_unit #(
    parameter int OFFSET_WIDTH = 32,
    parameter int LINE_WIDTH   = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire stt_pkg::t_byte_in i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output stt_pkg::t_tok          o_data
);

    typedef enum logic [10:0] {
        MD_BOM     = 11'b00000000001,
        MD_IDLE    = 11'b00000000010,
        MD_COMMENT = 11'b00000000100,
        MD_OP      = 11'b00000001000,
        MD_STR     = 11'b00000010000,
        MD_ESC     = 11'b00000100000,
        MD_INT     = 11'b00001000000,
        MD_DOT     = 11'b00010000000,
        MD_FLT     = 11'b00100000000,
        MD_ID      = 11'b01000000000,
        MD_ERR     = 11'b10000000000
    } t_mode;

    typedef struct packed {
        t_mode                   mode;
        logic [7:0]              pend;
        logic [LINE_WIDTH-1:0]   line;
        logic [LINE_WIDTH-1:0]   tline;
        logic [OFFSET_WIDTH-1:0] off;
        logic [OFFSET_WIDTH-1:0] tstart;
        logic [62:0]             acc;
        logic                    ovf;
        logic                    atls;
        logic [1:0]              bomc;
    } t_lex;

    typedef struct packed {
        t_lex          lx;
        logic [1:0]    n;
        stt_pkg::t_tok r0;
        stt_pkg::t_tok r1;
    } t_step;

    function automatic t_lex f_lex_rst();
        t_lex s;
        s.mode   = MD_BOM;
        s.pend   = '0;
        s.line   = LINE_WIDTH'(1);
        s.tline  = LINE_WIDTH'(1);
        s.off    = '0;
        s.tstart = '0;
        s.acc    = '0;
        s.ovf    = 1'b0;
        s.atls   = 1'b1;
        s.bomc   = '0;
        return s;
    endfunction

    function automatic logic [31:0] f_o32(logic [OFFSET_WIDTH-1:0] v);
        logic [OFFSET_WIDTH+31:0] t;
        t = {32'b0, v};
        return t[31:0];
    endfunction

    function automatic logic [31:0] f_l32(logic [LINE_WIDTH-1:0] v);
        logic [LINE_WIDTH+31:0] t;
        t = {32'b0, v};
        return t[31:0];
    endfunction

    function automatic logic [OFFSET_WIDTH-1:0] f_oinc(logic [OFFSET_WIDTH-1:0] v);
        return (v != '1) ? v + OFFSET_WIDTH'(1) : v;
    endfunction

    function automatic logic [LINE_WIDTH-1:0] f_linc(logic [LINE_WIDTH-1:0] v);
        return (v != '1) ? v + LINE_WIDTH'(1) : v;
    endfunction

    function automatic stt_pkg::t_tok f_tok(logic [2:0] kind, logic [4:0] code,
                                            logic [31:0] line, logic [31:0] start,
                                            logic [31:0] len, logic [62:0] val,
                                            logic [1:0] err);
        stt_pkg::t_tok t;
        t.token_kind  = kind;
        t.punct_code  = code;
        t.line_number = line;
        t.text_start  = start;
        t.text_length = len;
        t.int_value   = val;
        t.error_code  = err;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    function automatic logic f_digit(logic [7:0] b);
        return (b >= stt_pkg::CH_ZERO) && (b <= stt_pkg::CH_NINE);
    endfunction

    function automatic logic f_idstart(logic [7:0] b);
        return ((b >= stt_pkg::CH_LC_A) && (b <= stt_pkg::CH_LC_Z)) ||
               ((b >= stt_pkg::CH_UC_A) && (b <= stt_pkg::CH_UC_Z)) ||
               (b == stt_pkg::CH_UNDER);
    endfunction

    // bit 5: match, bits 4:0: operator code
    function automatic logic [5:0] f_single(logic [7:0] b);
        logic [5:0] r;
        unique case (b)
            stt_pkg::CH_EQ:     r = {1'b1, stt_pkg::P_ASSIGN};
            stt_pkg::CH_LT:     r = {1'b1, stt_pkg::P_LT};
            stt_pkg::CH_GT:     r = {1'b1, stt_pkg::P_GT};
            stt_pkg::CH_PLUS:   r = {1'b1, stt_pkg::P_PLUS};
            stt_pkg::CH_MINUS:  r = {1'b1, stt_pkg::P_MINUS};
            stt_pkg::CH_STAR:   r = {1'b1, stt_pkg::P_STAR};
            stt_pkg::CH_SLASH:  r = {1'b1, stt_pkg::P_SLASH};
            stt_pkg::CH_PCT:    r = {1'b1, stt_pkg::P_PERCENT};
            stt_pkg::CH_LPAREN: r = {1'b1, stt_pkg::P_LPAREN};
            stt_pkg::CH_RPAREN: r = {1'b1, stt_pkg::P_RPAREN};
            stt_pkg::CH_LBRACK: r = {1'b1, stt_pkg::P_LBRACK};
            stt_pkg::CH_RBRACK: r = {1'b1, stt_pkg::P_RBRACK};
            stt_pkg::CH_COMMA:  r = {1'b1, stt_pkg::P_COMMA};
            stt_pkg::CH_COLON:  r = {1'b1, stt_pkg::P_COLON};
            stt_pkg::CH_BANG:   r = {1'b1, stt_pkg::P_BANG};
            stt_pkg::CH_DOT:    r = {1'b1, stt_pkg::P_DOT};
            default:            r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] f_pair(logic [7:0] p, logic [7:0] b);
        logic [5:0] r;
        r = '0;
        if (b == stt_pkg::CH_EQ) begin
            if (p == stt_pkg::CH_EQ)   r = {1'b1, stt_pkg::P_EQEQ};
            if (p == stt_pkg::CH_BANG) r = {1'b1, stt_pkg::P_NE};
            if (p == stt_pkg::CH_LT)   r = {1'b1, stt_pkg::P_LE};
            if (p == stt_pkg::CH_GT)   r = {1'b1, stt_pkg::P_GE};
        end
        if (p == stt_pkg::CH_AMP && b == stt_pkg::CH_AMP) r = {1'b1, stt_pkg::P_ANDAND};
        if (p == stt_pkg::CH_BAR && b == stt_pkg::CH_BAR) r = {1'b1, stt_pkg::P_OROR};
        return r;
    endfunction

    function automatic t_step f_start(t_lex s, logic [7:0] b);
        t_step      r;
        logic [5:0] sc;
        r.lx        = s;
        r.n         = '0;
        r.r0        = '0;
        r.r1        = '0;
        sc          = f_single(b);
        r.lx.mode   = MD_IDLE;
        r.lx.tline  = s.line;
        r.lx.tstart = s.off;
        priority if (b == stt_pkg::CH_CR || b == stt_pkg::CH_SPACE || b == stt_pkg::CH_TAB) begin
            r.n = '0;
        end else if (b == stt_pkg::CH_LF) begin
            if (!s.atls) begin
                r.r0      = f_tok(stt_pkg::K_NL, stt_pkg::P_NONE, f_l32(s.line), '0, '0, '0,
                                  stt_pkg::E_NONE);
                r.n       = 2'd1;
                r.lx.atls = 1'b1;
            end
            r.lx.line = f_linc(s.line);
        end else if (b == stt_pkg::CH_HASH) begin
            r.lx.mode = MD_COMMENT;
        end else if (b == stt_pkg::CH_QUOTE) begin
            r.lx.mode   = MD_STR;
            r.lx.tstart = f_oinc(s.off);
        end else if (f_digit(b)) begin
            r.lx.mode = MD_INT;
            r.lx.acc  = 63'(b[3:0]);
            r.lx.ovf  = 1'b0;
        end else if (f_idstart(b)) begin
            r.lx.mode = MD_ID;
        end else if (b == stt_pkg::CH_EQ || b == stt_pkg::CH_BANG || b == stt_pkg::CH_LT ||
                     b == stt_pkg::CH_GT || b == stt_pkg::CH_AMP || b == stt_pkg::CH_BAR ||
                     b == stt_pkg::CH_SLASH) begin
            r.lx.mode = MD_OP;
            r.lx.pend = b;
        end else if (sc[5]) begin
            r.r0      = f_tok(stt_pkg::K_PUNCT, sc[4:0], f_l32(s.line), f_o32(s.off), 32'd1,
                              '0, stt_pkg::E_NONE);
            r.n       = 2'd1;
            r.lx.atls = 1'b0;
        end else begin
            r.r0      = f_tok(stt_pkg::K_ERR, stt_pkg::P_NONE, f_l32(s.line), f_o32(s.off),
                              '0, '0, stt_pkg::E_INVALID);
            r.n       = 2'd1;
            r.lx.mode = MD_ERR;
        end
        return r;
    endfunction

    // close the open token; fin is the offset just past its last byte
    function automatic t_step f_finish(t_lex s, logic [OFFSET_WIDTH-1:0] fin);
        t_step                   r;
        logic [5:0]              sc;
        logic [OFFSET_WIDTH-1:0] len;
        logic [31:0]             tl;
        logic [31:0]             ts;
        r.lx      = s;
        r.n       = '0;
        r.r0      = '0;
        r.r1      = '0;
        r.lx.mode = MD_IDLE;
        sc        = f_single(s.pend);
        len       = fin - s.tstart;
        tl        = f_l32(s.tline);
        ts        = f_o32(s.tstart);
        unique case (s.mode)
            MD_INT, MD_DOT: begin
                if (s.ovf) begin
                    r.r0      = f_tok(stt_pkg::K_ERR, stt_pkg::P_NONE, tl, ts, '0, '0,
                                      stt_pkg::E_OVERFLOW);
                    r.n       = 2'd1;
                    r.lx.mode = MD_ERR;
                end else if (s.mode == MD_DOT) begin
                    r.r0      = f_tok(stt_pkg::K_INT, stt_pkg::P_NONE, tl, ts,
                                      f_o32(len - OFFSET_WIDTH'(1)), s.acc, stt_pkg::E_NONE);
                    r.r1      = f_tok(stt_pkg::K_PUNCT, stt_pkg::P_DOT, tl,
                                      f_o32(fin - OFFSET_WIDTH'(1)), 32'd1, '0, stt_pkg::E_NONE);
                    r.n       = 2'd2;
                    r.lx.atls = 1'b0;
                end else begin
                    r.r0      = f_tok(stt_pkg::K_INT, stt_pkg::P_NONE, tl, ts, f_o32(len), s.acc,
                                      stt_pkg::E_NONE);
                    r.n       = 2'd1;
                    r.lx.atls = 1'b0;
                end
            end
            MD_FLT: begin
                r.r0      = f_tok(stt_pkg::K_FLT, stt_pkg::P_NONE, tl, ts, f_o32(len), '0,
                                  stt_pkg::E_NONE);
                r.n       = 2'd1;
                r.lx.atls = 1'b0;
            end
            MD_ID: begin
                r.r0      = f_tok(stt_pkg::K_ID, stt_pkg::P_NONE, tl, ts, f_o32(len), '0,
                                  stt_pkg::E_NONE);
                r.n       = 2'd1;
                r.lx.atls = 1'b0;
            end
            MD_OP: begin
                if (sc[5]) begin
                    r.r0      = f_tok(stt_pkg::K_PUNCT, sc[4:0], tl, ts, 32'd1, '0,
                                      stt_pkg::E_NONE);
                    r.lx.atls = 1'b0;
                end else begin
                    r.r0      = f_tok(stt_pkg::K_ERR, stt_pkg::P_NONE, tl, ts, '0, '0,
                                      stt_pkg::E_INVALID);
                    r.lx.mode = MD_ERR;
                end
                r.n = 2'd1;
            end
            MD_STR, MD_ESC: begin
                r.r0      = f_tok(stt_pkg::K_ERR, stt_pkg::P_NONE, tl, ts, '0, '0,
                                  stt_pkg::E_UNTERM);
                r.n       = 2'd1;
                r.lx.mode = MD_ERR;
            end
            MD_BOM: begin
                if (s.bomc != 2'd0) begin
                    r.r0      = f_tok(stt_pkg::K_ERR, stt_pkg::P_NONE, 32'd1, '0, '0, '0,
                                      stt_pkg::E_INVALID);
                    r.n       = 2'd1;
                    r.lx.mode = MD_ERR;
                end
            end
            default: r.lx.mode = MD_IDLE;
        endcase
        return r;
    endfunction

    t_lex          r_lex;
    t_lex          n_lex;
    stt_pkg::t_tok r_res [4];
    stt_pkg::t_tok n_res [4];
    logic [2:0]    r_cnt;
    logic [2:0]    n_cnt;
    logic [1:0]    r_head;
    logic          in_fire;
    logic          out_fire;

    assign o_valid  = (r_cnt != 3'd0);
    assign o_data   = r_res[r_head];
    assign out_fire = o_valid && !i_stall;
    assign o_stall  = !((r_cnt == 3'd0) || ((r_cnt == 3'd1) && out_fire));
    assign in_fire  = i_valid && !o_stall;

    always_comb begin
        t_lex          s;
        t_lex          lx;
        t_step         fin;
        t_step         st0;
        t_step         st1;
        t_step         st;
        t_step         fb;
        stt_pkg::t_tok dr;
        logic          use_fin;
        logic          use_st;
        logic          use_dr;
        logic [5:0]    pc;
        logic [7:0]    b;
        logic [66:0]   wide;
        logic [2:0]    cnt;
        s       = r_lex;
        b       = i_data.char_byte;
        fin     = f_finish(s, s.off);
        st0     = f_start(s, b);
        st1     = f_start(fin.lx, b);
        pc      = f_pair(s.pend, b);
        wide    = {1'b0, s.acc, 3'b0} + {3'b0, s.acc, 1'b0} + 67'(b[3:0]);
        lx      = s;
        use_fin = 1'b0;
        use_st  = 1'b0;
        use_dr  = 1'b0;
        dr      = '0;
        st      = st0;
        cnt     = '0;
        for (int i = 0; i < 4; i++) begin
            n_res[i] = '0;
        end

        if (i_data.has_byte) begin
            unique case (s.mode)
                MD_ERR: lx = s;
                MD_BOM: begin
                    if (s.bomc == 2'd0) begin
                        if (b == stt_pkg::CH_BOM0) begin
                            lx.bomc = 2'd1;
                        end else begin
                            lx     = st0.lx;
                            use_st = 1'b1;
                        end
                    end else if ((s.bomc == 2'd1 && b == stt_pkg::CH_BOM1) ||
                                 (s.bomc == 2'd2 && b == stt_pkg::CH_BOM2)) begin
                        lx.bomc = (s.bomc == 2'd1) ? 2'd2 : 2'd0;
                        lx.mode = (s.bomc == 2'd1) ? MD_BOM : MD_IDLE;
                    end else begin
                        dr      = f_tok(stt_pkg::K_ERR, stt_pkg::P_NONE, 32'd1, '0, '0, '0,
                                        stt_pkg::E_INVALID);
                        use_dr  = 1'b1;
                        lx.mode = MD_ERR;
                    end
                end
                MD_IDLE: begin
                    lx     = st0.lx;
                    use_st = 1'b1;
                end
                MD_COMMENT: begin
                    if (b == stt_pkg::CH_LF) begin
                        lx     = st0.lx;
                        use_st = 1'b1;
                    end
                end
                MD_OP: begin
                    if (s.pend == stt_pkg::CH_SLASH && b == stt_pkg::CH_SLASH) begin
                        lx.mode = MD_COMMENT;
                    end else if (pc[5]) begin
                        dr      = f_tok(stt_pkg::K_PUNCT, pc[4:0], f_l32(s.tline),
                                        f_o32(s.tstart), 32'd2, '0, stt_pkg::E_NONE);
                        use_dr  = 1'b1;
                        lx.mode = MD_IDLE;
                        lx.atls = 1'b0;
                    end else begin
                        use_fin = 1'b1;
                    end
                end
                MD_STR: begin
                    if (b == stt_pkg::CH_QUOTE) begin
                        dr      = f_tok(stt_pkg::K_STR, stt_pkg::P_NONE, f_l32(s.tline),
                                        f_o32(s.tstart), f_o32(s.off - s.tstart), '0,
                                        stt_pkg::E_NONE);
                        use_dr  = 1'b1;
                        lx.mode = MD_IDLE;
                        lx.atls = 1'b0;
                    end else if (b == stt_pkg::CH_BSLASH) begin
                        lx.mode = MD_ESC;
                    end else if (b == stt_pkg::CH_LF) begin
                        lx.line = f_linc(s.line);
                    end
                end
                MD_ESC: lx.mode = MD_STR;
                MD_INT: begin
                    if (f_digit(b)) begin
                        if (s.ovf || (wide[66:63] != 4'd0)) lx.ovf = 1'b1;
                        else lx.acc = wide[62:0];
                    end else if (b == stt_pkg::CH_DOT) begin
                        lx.mode = MD_DOT;
                    end else begin
                        use_fin = 1'b1;
                    end
                end
                MD_DOT, MD_FLT: begin
                    if (f_digit(b)) lx.mode = MD_FLT;
                    else use_fin = 1'b1;
                end
                MD_ID: begin
                    if (!(f_idstart(b) || f_digit(b))) use_fin = 1'b1;
                end
                default: lx.mode = MD_IDLE;
            endcase

            if (use_fin) begin
                lx = fin.lx;
                if (fin.lx.mode != MD_ERR) begin
                    lx     = st1.lx;
                    st     = st1;
                    use_st = 1'b1;
                end
            end

            if (use_fin && fin.n != 2'd0) begin
                n_res[cnt[1:0]] = fin.r0;
                cnt             = cnt + 3'd1;
            end
            if (use_fin && fin.n == 2'd2) begin
                n_res[cnt[1:0]] = fin.r1;
                cnt             = cnt + 3'd1;
            end
            if (use_st && st.n != 2'd0) begin
                n_res[cnt[1:0]] = st.r0;
                cnt             = cnt + 3'd1;
            end
            if (use_dr) begin
                n_res[cnt[1:0]] = dr;
                cnt             = cnt + 3'd1;
            end
            lx.off = f_oinc(lx.off);
        end

        if (i_data.end_of_source) begin
            fb = f_finish(lx, lx.off);
            if (lx.mode != MD_ERR) begin
                if (fb.n != 2'd0 && cnt < 3'd4) begin
                    n_res[cnt[1:0]] = fb.r0;
                    cnt             = cnt + 3'd1;
                end
                if (fb.n == 2'd2 && cnt < 3'd4) begin
                    n_res[cnt[1:0]] = fb.r1;
                    cnt             = cnt + 3'd1;
                end
                lx = fb.lx;
            end
            if (lx.mode != MD_ERR && !lx.atls && cnt <= 3'd2) begin
                n_res[cnt[1:0]] = f_tok(stt_pkg::K_NL, stt_pkg::P_NONE, f_l32(lx.line), '0, '0,
                                        '0, stt_pkg::E_NONE);
                cnt             = cnt + 3'd1;
            end
            if (cnt < 3'd4) begin
                n_res[cnt[1:0]] = f_tok(stt_pkg::K_EOF, stt_pkg::P_NONE, f_l32(lx.line),
                                        f_o32(lx.off), '0, '0, stt_pkg::E_NONE);
                cnt             = cnt + 3'd1;
            end
            lx = f_lex_rst();
        end

        if (cnt != 3'd0) begin
            n_res[2'(cnt - 3'd1)].last_of_run = 1'b1;
        end
        n_lex = lx;
        n_cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex  <= f_lex_rst();
            r_cnt  <= '0;
            r_head <= '0;
        end else if (in_fire) begin
            r_lex  <= n_lex;
            r_cnt  <= n_cnt;
            r_head <= '0;
        end else if (out_fire) begin
            r_cnt  <= r_cnt - 3'd1;
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== src/stt_check.sv =====
// ----------------------------------------------------------------------------
// stt_check
// Port-level checks of the source text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_check (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire stt_pkg::t_byte_in i_data,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire stt_pkg::t_tok     o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.last_of_run |=> o_valid)
        else $error("result run broken");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.token_kind == stt_pkg::K_EOF |-> o_data.last_of_run)
        else $error("eof not last of run");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.token_kind == stt_pkg::K_ERR) ==
                     (o_data.error_code != stt_pkg::E_NONE)))
        else $error("error code mismatch");

    a_eos_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.end_of_source |=> o_valid)
        else $error("end of source gave no result");

endmodule

bind source_text_tokenizer_unit stt_check u_stt_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

// ===== bench/token_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_checker
// Watches both channels of the source text tokenizer, predicts the token
// descriptors of every accepted byte transfer and compares each emitted
// descriptor, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module token_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire stt_pkg::t_byte_in i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire stt_pkg::t_tok     i_out_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_tokens_seen
);
    import stt_pkg::*;

    typedef enum logic [3:0] {
        LX_BOM, LX_IDLE, LX_COMMENT, LX_OP, LX_STR, LX_ESC,
        LX_INT, LX_DOT, LX_FLT, LX_ID, LX_ERR
    } t_lex;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
    localparam int          RUN_MAX = 4;

    t_lex        lx_mode;
    logic [7:0]  lx_pend;
    logic [31:0] lx_line, lx_tok_line, lx_offset, lx_tok_start;
    logic [62:0] lx_acc;
    logic        lx_ovf, lx_line_start;
    logic [1:0]  lx_bom;

    t_tok expected_tokens[$];
    t_tok run_tokens[$];

    assign o_pending = expected_tokens.size();

    function automatic logic is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic is_id_start(logic [7:0] b);
        return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z)
            || b == CH_UNDER;
    endfunction

    function automatic int single_op(logic [7:0] b);
        case (b)
            CH_EQ:     return P_ASSIGN;
            CH_LT:     return P_LT;
            CH_GT:     return P_GT;
            CH_PLUS:   return P_PLUS;
            CH_MINUS:  return P_MINUS;
            CH_STAR:   return P_STAR;
            CH_SLASH:  return P_SLASH;
            CH_PCT:    return P_PERCENT;
            CH_LPAREN: return P_LPAREN;
            CH_RPAREN: return P_RPAREN;
            CH_LBRACK: return P_LBRACK;
            CH_RBRACK: return P_RBRACK;
            CH_COMMA:  return P_COMMA;
            CH_COLON:  return P_COLON;
            CH_BANG:   return P_BANG;
            CH_DOT:    return P_DOT;
            default:   return -1;
        endcase
    endfunction

    function automatic int pair_op(logic [7:0] p, logic [7:0] b);
        if (b == CH_EQ) begin
            if (p == CH_EQ) return P_EQEQ;
            if (p == CH_BANG) return P_NE;
            if (p == CH_LT) return P_LE;
            if (p == CH_GT) return P_GE;
        end
        if (p == CH_AMP && b == CH_AMP) return P_ANDAND;
        if (p == CH_BAR && b == CH_BAR) return P_OROR;
        return -1;
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v != CNT_MAX) ? v + 32'd1 : v;
    endfunction

    task automatic push_token(logic [2:0] kind, logic [4:0] code, logic [31:0] line,
                              logic [31:0] start, logic [31:0] len, logic [62:0] val,
                              logic [1:0] err);
        t_tok t;
        if (run_tokens.size() >= RUN_MAX) return;
        t.token_kind  = kind;
        t.punct_code  = code;
        t.line_number = line;
        t.text_start  = start;
        t.text_length = len;
        t.int_value   = val;
        t.error_code  = err;
        t.last_of_run = 1'b0;
        run_tokens = {run_tokens, t};
    endtask

    task automatic raise_error(logic [1:0] err, logic [31:0] line, logic [31:0] start);
        push_token(K_ERR, P_NONE, line, start, 32'd0, 63'd0, err);
        lx_mode = LX_ERR;
    endtask

    task automatic push_text(logic [2:0] kind, logic [4:0] code, logic [31:0] start,
                             logic [31:0] len, logic [62:0] val);
        push_token(kind, code, lx_tok_line, start, len, val, E_NONE);
        lx_line_start = 1'b0;
    endtask

    task automatic close_token(logic [31:0] stop);
        logic [31:0] len;
        int c;
        len = stop - lx_tok_start;
        case (lx_mode)
            LX_INT, LX_DOT: begin
                if (lx_ovf) begin
                    raise_error(E_OVERFLOW, lx_tok_line, lx_tok_start);
                    return;
                end
                if (lx_mode == LX_DOT) begin
                    push_text(K_INT, P_NONE, lx_tok_start, len - 32'd1, lx_acc);
                    push_text(K_PUNCT, P_DOT, stop - 32'd1, 32'd1, 63'd0);
                end else begin
                    push_text(K_INT, P_NONE, lx_tok_start, len, lx_acc);
                end
            end
            LX_FLT: push_text(K_FLT, P_NONE, lx_tok_start, len, 63'd0);
            LX_ID: push_text(K_ID, P_NONE, lx_tok_start, len, 63'd0);
            LX_OP: begin
                c = single_op(lx_pend);
                if (c < 0) begin
                    raise_error(E_INVALID, lx_tok_line, lx_tok_start);
                    return;
                end
                push_text(K_PUNCT, c[4:0], lx_tok_start, 32'd1, 63'd0);
            end
            LX_STR, LX_ESC: begin
                raise_error(E_UNTERM, lx_tok_line, lx_tok_start);
                return;
            end
            LX_BOM: begin
                if (lx_bom != 2'd0) begin
                    raise_error(E_INVALID, 32'd1, 32'd0);
                    return;
                end
            end
            default: ;
        endcase
        lx_mode = LX_IDLE;
    endtask

    task automatic open_token(logic [7:0] b, logic [31:0] cur);
        int c;
        lx_mode = LX_IDLE;
        lx_tok_line = lx_line;
        lx_tok_start = cur;
        if (b == CH_CR || b == CH_SPACE || b == CH_TAB) return;
        if (b == CH_LF) begin
            if (!lx_line_start) begin
                push_token(K_NL, P_NONE, lx_line, 32'd0, 32'd0, 63'd0, E_NONE);
                lx_line_start = 1'b1;
            end
            lx_line = sat_inc(lx_line);
            return;
        end
        if (b == CH_HASH) begin
            lx_mode = LX_COMMENT;
            return;
        end
        if (b == CH_QUOTE) begin
            lx_mode = LX_STR;
            lx_tok_start = sat_inc(cur);
            return;
        end
        if (is_digit(b)) begin
            lx_mode = LX_INT;
            lx_acc = 63'(b - CH_ZERO);
            lx_ovf = 1'b0;
            return;
        end
        if (is_id_start(b)) begin
            lx_mode = LX_ID;
            return;
        end
        if (b == CH_EQ || b == CH_BANG || b == CH_LT || b == CH_GT || b == CH_AMP
                || b == CH_BAR || b == CH_SLASH) begin
            lx_mode = LX_OP;
            lx_pend = b;
            return;
        end
        c = single_op(b);
        if (c >= 0) begin
            push_text(K_PUNCT, c[4:0], cur, 32'd1, 63'd0);
            return;
        end
        raise_error(E_INVALID, lx_line, cur);
    endtask

    task automatic close_and_open(logic [7:0] b, logic [31:0] cur);
        close_token(cur);
        if (lx_mode != LX_ERR) open_token(b, cur);
    endtask

    task automatic lex_byte(logic [7:0] b);
        logic [31:0] cur;
        logic [63:0] d;
        int c;
        cur = lx_offset;
        case (lx_mode)
            LX_ERR: ;
            LX_BOM: begin
                if (lx_bom == 2'd0) begin
                    if (b == CH_BOM0) lx_bom = 2'd1;
                    else open_token(b, cur);
                end else if (lx_bom == 2'd1) begin
                    if (b == CH_BOM1) lx_bom = 2'd2;
                    else raise_error(E_INVALID, 32'd1, 32'd0);
                end else begin
                    if (b == CH_BOM2) begin
                        lx_bom = 2'd0;
                        lx_mode = LX_IDLE;
                    end else begin
                        raise_error(E_INVALID, 32'd1, 32'd0);
                    end
                end
            end
            LX_IDLE: open_token(b, cur);
            LX_COMMENT: if (b == CH_LF) open_token(b, cur);
            LX_OP: begin
                c = pair_op(lx_pend, b);
                if (lx_pend == CH_SLASH && b == CH_SLASH) begin
                    lx_mode = LX_COMMENT;
                end else if (c >= 0) begin
                    push_text(K_PUNCT, c[4:0], lx_tok_start, 32'd2, 63'd0);
                    lx_mode = LX_IDLE;
                end else begin
                    close_and_open(b, cur);
                end
            end
            LX_STR: begin
                if (b == CH_QUOTE) begin
                    push_text(K_STR, P_NONE, lx_tok_start, cur - lx_tok_start, 63'd0);
                    lx_mode = LX_IDLE;
                end else if (b == CH_BSLASH) begin
                    lx_mode = LX_ESC;
                end else if (b == CH_LF) begin
                    lx_line = sat_inc(lx_line);
                end
            end
            LX_ESC: lx_mode = LX_STR;
            LX_INT: begin
                if (is_digit(b)) begin
                    d = 64'(b - CH_ZERO);
                    if (lx_ovf || 64'(lx_acc) > (64'(INT_MAX) - d) / 64'd10)
                        lx_ovf = 1'b1;
                    else
                        lx_acc = 63'(64'(lx_acc) * 64'd10 + d);
                end else if (b == CH_DOT) begin
                    lx_mode = LX_DOT;
                end else begin
                    close_and_open(b, cur);
                end
            end
            LX_DOT, LX_FLT: begin
                if (is_digit(b)) lx_mode = LX_FLT;
                else close_and_open(b, cur);
            end
            LX_ID: begin
                if (!(is_id_start(b) || is_digit(b))) close_and_open(b, cur);
            end
            default: lx_mode = LX_IDLE;
        endcase
        lx_offset = sat_inc(lx_offset);
    endtask

    task automatic lex_reset();
        lx_mode = LX_BOM;
        lx_pend = 8'd0;
        lx_line = 32'd1;
        lx_tok_line = 32'd1;
        lx_offset = 32'd0;
        lx_tok_start = 32'd0;
        lx_acc = 63'd0;
        lx_ovf = 1'b0;
        lx_line_start = 1'b1;
        lx_bom = 2'd0;
    endtask

    task automatic predict_tokens(t_byte_in item);
        t_tok t;
        run_tokens.delete();
        if (item.has_byte) lex_byte(item.char_byte);
        if (item.end_of_source) begin
            if (lx_mode != LX_ERR) close_token(lx_offset);
            if (lx_mode != LX_ERR && !lx_line_start && run_tokens.size() <= RUN_MAX - 2)
                push_token(K_NL, P_NONE, lx_line, 32'd0, 32'd0, 63'd0, E_NONE);
            push_token(K_EOF, P_NONE, lx_line, lx_offset, 32'd0, 63'd0, E_NONE);
            lex_reset();
        end
        foreach (run_tokens[i]) begin
            t = run_tokens[i];
            t.last_of_run = (i == run_tokens.size() - 1);
            expected_tokens = {expected_tokens, t};
        end
    endtask

    task automatic compare_token(t_tok got);
        t_tok want;
        if (expected_tokens.size() == 0) begin
            $error("unexpected token transfer: kind %0d", got.token_kind);
            o_fail_count++;
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
            o_fail_count++;
        end
        if (got.punct_code !== want.punct_code) begin
            $error("punct_code: expected %0d, got %0d", want.punct_code, got.punct_code);
            o_fail_count++;
        end
        if (got.line_number !== want.line_number) begin
            $error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
            o_fail_count++;
        end
        if (got.text_start !== want.text_start) begin
            $error("text_start: expected %0d, got %0d", want.text_start, got.text_start);
            o_fail_count++;
        end
        if (got.text_length !== want.text_length) begin
            $error("text_length: expected %0d, got %0d", want.text_length, got.text_length);
            o_fail_count++;
        end
        if (got.int_value !== want.int_value) begin
            $error("int_value: expected %0d, got %0d", want.int_value, got.int_value);
            o_fail_count++;
        end
        if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            o_fail_count++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_tokens_seen = 0;
        lex_reset();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lex_reset();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_token(i_out_data);
                o_tokens_seen++;
            end
            if (i_in_valid && !i_in_stall) predict_tokens(i_in_data);
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the source text tokenizer with directed and random source text,
// stalls its output at random and once for a long stretch, and reports the
// verdict from the token checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic     i_clk;
    logic     i_rst_n;
    logic     in_valid;
    logic     in_stall;
    t_byte_in in_data;
    logic     out_valid;
    logic     out_stall;
    t_tok     out_data;
    int       fail_count;
    int       pending;
    int       tokens_seen;
    int       cycle_count;
    int       items_sent;
    logic     hold_off;

    source_text_tokenizer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    token_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_tokens_seen (tokens_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // pick a byte from source-like classes, rarely anything at all
    function automatic logic [7:0] pick_char();
        int r;
        logic [7:0] ops[20];
        ops = '{CH_EQ, CH_LT, CH_GT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT,
                CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON,
                CH_BANG, CH_DOT, CH_AMP, CH_BAR, CH_QUOTE, CH_HASH};
        r = $urandom_range(0, 99);
        if (r < 25) return CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 45) return CH_LC_A + 8'($urandom_range(0, 25));
        if (r < 50) return CH_UC_A + 8'($urandom_range(0, 25));
        if (r < 70) return ops[$urandom_range(0, 19)];
        if (r < 80) return CH_SPACE;
        if (r < 87) return CH_LF;
        if (r < 89) return CH_TAB;
        if (r < 90) return CH_CR;
        if (r < 92) return CH_BSLASH;
        if (r < 94) return CH_UNDER;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send(logic [7:0] b, logic has_b, logic eos);
        repeat (gap_len()) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{char_byte: b, has_byte: has_b, end_of_source: eos};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(string s, logic eos);
        for (int i = 0; i < s.len(); i++)
            send(s[i], 1'b1, eos && i == s.len() - 1);
    endtask

    initial begin
        in_valid = 1'b0;
        in_data  = '0;
        i_rst_n  = 1'b0;
        hold_off = 1'b0;
        items_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(CH_BOM0, 1'b1, 1'b0);
        send(CH_BOM1, 1'b1, 1'b0);
        send(CH_BOM2, 1'b1, 1'b0);
        send_text("a==1.5!=x<=2>=3&&y||\"q\\\"\n\"//c\n#z\n9.(", 1'b0);
        send(8'd0, 1'b0, 1'b1);
        send(CH_BOM0, 1'b1, 1'b0);
        send(CH_ZERO, 1'b1, 1'b1);
        send_text("99999999999999999999 ", 1'b1);
        send_text("12. ", 1'b0);
        send(CH_AMP, 1'b1, 1'b0);
        send(8'd0, 1'b0, 1'b1);
        send_text("\"ab", 1'b1);
        send(8'd0, 1'b1, 1'b1);
        send(8'hFF, 1'b1, 1'b0);
        send(8'd0, 1'b0, 1'b0);
        send(CH_DOT, 1'b1, 1'b1);
        send_text("9223372036854775807+-*%()[],:\n=<>!", 1'b0);
        send(CH_BAR, 1'b1, 1'b1);
        send_text("x 1.", 1'b1);

        // let the receiver block while input keeps coming
        hold_off = 1'b1;
        send_text("a b c d e f g h i j k l m n", 1'b0);
        hold_off = 1'b0;

        while (items_sent < 209) begin
            if ($urandom_range(0, 39) == 0) send(8'($urandom_range(0, 255)),
                                                 1'($urandom_range(0, 1)), 1'b1);
            else send(pick_char(), 1'b1, 1'b0);
        end
        send(8'd0, 1'b0, 1'b1);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d byte transfers, checked %0d token transfers.",
                 items_sent, tokens_seen);
        if (fail_count == 0)
            $display("[source_text_tokenizer_unit] OK");
        else
            $display("[source_text_tokenizer_unit] ERROR");
        $finish;
    end

    initial begin
        out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                out_stall <= 1'b0;
                while (hold_off) @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat (gap_len()) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("[source_text_tokenizer_unit] ERROR");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
